/* sv/wmcd_pkg.sv */
// Shared types, constants and state encodings for the min/max column decimator.
package wmcd_pkg;

  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned MAX_COLUMNS_DEF = 4096;
  localparam int unsigned MAX_SCALE       = 4;
  localparam int unsigned COL_MAX_W       = 14;
  localparam int unsigned DEV_W           = 14;
  localparam int unsigned PROD_W          = 46;
  localparam int unsigned P_W             = 16;
  localparam int unsigned JOB_DEPTH       = 2;
  localparam int unsigned CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_OFFSET  = 3'd0,
    REG_WINDOW_FRAMES  = 3'd1,
    REG_LOGICAL_WIDTH  = 3'd2,
    REG_LOGICAL_HEIGHT = 3'd3,
    REG_PIXEL_SCALE    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] window_offset;
    logic [31:0] window_frames;
    logic [12:0] logical_width;
    logic [12:0] logical_height;
    logic [2:0]  pixel_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    window_offset:  32'd0,
    window_frames:  32'd4096,
    logical_width:  13'd1024,
    logical_height: 13'd256,
    pixel_scale:    3'd1
  };

  typedef struct packed {
    logic [31:0]                   frame_index;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          end_of_clip;
  } in_item_t;

  typedef struct packed {
    logic [DEV_W-1:0] device_column;
    logic [DEV_W-1:0] row_top;
    logic [DEV_W-1:0] row_bottom;
    logic             setup_error;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic                          setup_error;
    logic [COL_MAX_W-1:0]          column;
    logic signed [SAMPLE_BITS-1:0] col_max;
    logic signed [SAMPLE_BITS-1:0] col_min;
  } job_t;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_CLASSIFY,
    FE_MUL,
    FE_DIV,
    FE_MUL2,
    FE_UPDATE,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_MULT,
    BE_ROW,
    BE_EMIT
  } be_state_e;

endpackage

/* sv/wmcd_front.sv */
// Front end: accepts frames, finds their column by long division and keeps the column extremes.
module wmcd_front #(
  parameter int unsigned MAX_COLUMNS = wmcd_pkg::MAX_COLUMNS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wmcd_pkg::cfg_t     cfg_i,
  input  logic               restart_i,
  input  logic               push_i,
  output logic               full_o,
  input  wmcd_pkg::in_item_t item_i,
  output logic               job_push_o,
  output wmcd_pkg::job_t     job_o,
  input  logic               job_full_i
);

  localparam int unsigned CW    = $clog2(MAX_COLUMNS);
  localparam int unsigned CNT_W = $clog2(CW);
  localparam int unsigned SB    = wmcd_pkg::SAMPLE_BITS;
  localparam int unsigned PW    = wmcd_pkg::PROD_W;

  wmcd_pkg::fe_state_e state_q, state_d;
  wmcd_pkg::in_item_t  item_q, item_d;
  wmcd_pkg::job_t      job_q, job_d;
  logic [31:0]         r_q, r_d;
  logic [PW-1:0]       rem_q, rem_d;
  logic [PW-1:0]       dsr_q, dsr_d;
  logic [PW-1:0]       b_q, b_d;
  logic [PW-1:0]       bnd_q, bnd_d;
  logic [CW-1:0]       quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic signed [SB-1:0] min_q, min_d;
  logic signed [SB-1:0] max_q, max_d;
  logic                has_q, has_d;
  logic                done_q, done_d;

  logic                setup_bad;
  logic [31:0]         rel;
  logic [44:0]         rw;
  logic [PW-1:0]       w_ext;
  logic                ge;
  logic [CW:0]         cnext;
  logic [32+CW:0]      bnd_full;
  logic                close;
  logic                new_col;
  logic                last_col;
  logic signed [SB-1:0] s;
  logic signed [SB-1:0] lo;
  logic signed [SB-1:0] hi;

  assign setup_bad = (cfg_i.window_frames == '0) || (cfg_i.logical_width == '0) ||
                     (32'(cfg_i.logical_width) > 32'(MAX_COLUMNS)) ||
                     (cfg_i.logical_height == '0) || (cfg_i.pixel_scale == '0) ||
                     (32'(cfg_i.pixel_scale) > 32'(wmcd_pkg::MAX_SCALE)) ||
                     (cfg_i.window_frames < 32'(cfg_i.logical_width));

  assign rel      = item_q.frame_index - cfg_i.window_offset;
  assign rw       = 45'(r_q) * 45'(cfg_i.logical_width);
  assign w_ext    = PW'(cfg_i.logical_width);
  assign ge       = rem_q >= dsr_q;
  assign cnext    = (CW+1)'(quo_q) + (CW+1)'(1);
  assign bnd_full = (33+CW)'(cfg_i.window_frames) * (33+CW)'(cnext);
  assign close    = item_q.end_of_clip || (bnd_q < b_q);
  assign s        = item_q.sample_value;
  assign new_col  = !has_q || (quo_q != cur_q);
  assign lo       = (new_col || (s < min_q)) ? s : min_q;
  assign hi       = (new_col || (s > max_q)) ? s : max_q;
  assign last_col = (32'(quo_q) + 32'd1) >= 32'(cfg_i.logical_width);

  assign full_o = state_q != wmcd_pkg::FE_IDLE;
  assign job_o  = job_q;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    job_d      = job_q;
    r_d        = r_q;
    rem_d      = rem_q;
    dsr_d      = dsr_q;
    b_d        = b_q;
    bnd_d      = bnd_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    min_d      = min_q;
    max_d      = max_q;
    has_d      = has_q;
    done_d     = done_q;
    job_push_o = 1'b0;
    unique case (state_q)
      wmcd_pkg::FE_IDLE: begin
        if (push_i) begin
          item_d  = item_i;
          state_d = wmcd_pkg::FE_CLASSIFY;
        end
      end
      wmcd_pkg::FE_CLASSIFY: begin
        r_d = rel;
        if (setup_bad) begin
          job_d             = '0;
          job_d.setup_error = 1'b1;
          state_d           = wmcd_pkg::FE_PUSH;
        end else if (done_q) begin
          state_d = wmcd_pkg::FE_IDLE;
        end else if (item_q.frame_index < cfg_i.window_offset) begin
          has_d = 1'b0;
          if (item_q.end_of_clip) begin
            done_d = 1'b1;
          end
          state_d = wmcd_pkg::FE_IDLE;
        end else if (rel >= cfg_i.window_frames) begin
          has_d   = 1'b0;
          done_d  = 1'b1;
          state_d = wmcd_pkg::FE_IDLE;
        end else begin
          state_d = wmcd_pkg::FE_MUL;
        end
      end
      wmcd_pkg::FE_MUL: begin
        rem_d   = PW'(rw) + w_ext - PW'(1);
        b_d     = PW'(rw) + (w_ext << 1);
        dsr_d   = PW'(cfg_i.window_frames) << (CW - 1);
        quo_d   = '0;
        cnt_d   = CNT_W'(CW - 1);
        state_d = wmcd_pkg::FE_DIV;
      end
      wmcd_pkg::FE_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsr_q;
        end
        quo_d = {quo_q[CW-2:0], ge};
        dsr_d = dsr_q >> 1;
        if (cnt_q == '0) begin
          state_d = wmcd_pkg::FE_MUL2;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      wmcd_pkg::FE_MUL2: begin
        bnd_d   = PW'(bnd_full);
        state_d = wmcd_pkg::FE_UPDATE;
      end
      wmcd_pkg::FE_UPDATE: begin
        cur_d = quo_q;
        min_d = lo;
        max_d = hi;
        if (close) begin
          has_d             = 1'b0;
          done_d            = item_q.end_of_clip || last_col;
          job_d.setup_error = 1'b0;
          job_d.column      = wmcd_pkg::COL_MAX_W'(quo_q);
          job_d.col_max     = hi;
          job_d.col_min     = lo;
          state_d           = wmcd_pkg::FE_PUSH;
        end else begin
          has_d   = 1'b1;
          state_d = wmcd_pkg::FE_IDLE;
        end
      end
      wmcd_pkg::FE_PUSH: begin
        job_push_o = !job_full_i;
        if (!job_full_i) begin
          state_d = wmcd_pkg::FE_IDLE;
        end
      end
      default: begin
        state_d = wmcd_pkg::FE_IDLE;
      end
    endcase
    if (restart_i) begin
      cur_d  = '0;
      min_d  = '0;
      max_d  = '0;
      has_d  = 1'b0;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmcd_pkg::FE_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      has_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      min_q   <= min_d;
      max_q   <= max_d;
      has_q   <= has_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    job_q  <= job_d;
    r_q    <= r_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    b_q    <= b_d;
    bnd_q  <= bnd_d;
    quo_q  <= quo_d;
  end

  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wmcd_pkg::FE_UPDATE |-> 32'(quo_q) < 32'(cfg_i.logical_width))
    else $error("Column search produced a column beyond the image width.");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> !has_q && !done_q)
    else $error("A register write did not restart the window.");

endmodule

/* sv/wmcd_job_fifo.sv */
// Short queue of closed columns between the front end and the span generator.
module wmcd_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wmcd_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output wmcd_pkg::job_t job_o,
  output logic           empty_o
);

  localparam int unsigned DEPTH = wmcd_pkg::JOB_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  wmcd_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Front end offered a column while the queue was full.");

endmodule

/* sv/wmcd_back.sv */
// Back end: turns a closed column into device rows and emits one span per device column.
module wmcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wmcd_pkg::cfg_t      cfg_i,
  input  logic                job_empty_i,
  input  wmcd_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output wmcd_pkg::out_item_t out_item_o
);

  localparam int unsigned SB  = wmcd_pkg::SAMPLE_BITS;
  localparam int unsigned PWD = wmcd_pkg::P_W;
  localparam int unsigned DW  = wmcd_pkg::DEV_W;
  localparam int unsigned MW  = PWD + SB + 1;
  localparam int unsigned BW  = wmcd_pkg::COL_MAX_W + 3;
  localparam logic [SB:0] Q_EXT = {1'b0, 1'b1, {(SB-1){1'b0}}};

  function automatic logic [SB:0] q_minus(input logic [SB-1:0] smp);
    return Q_EXT - {smp[SB-1], smp};
  endfunction

  function automatic logic [DW-1:0] row_of(input logic [MW-1:0] prod,
                                           input logic [PWD-1:0] p);
    logic [MW:0]    num;
    logic [PWD+1:0] row;
    num = {1'b0, prod} + (MW+1)'(Q_EXT);
    row = num[MW:SB];
    if (row >= (PWD+2)'(p)) begin
      row = (PWD+2)'(p) - (PWD+2)'(1);
    end
    return row[DW-1:0];
  endfunction

  wmcd_pkg::be_state_e state_q, state_d;
  wmcd_pkg::job_t      job_q, job_d;
  wmcd_pkg::out_item_t out_q, out_d;
  logic                outv_q, outv_d;
  logic [2:0]          k_q, k_d;
  logic [PWD-1:0]      p_q;
  logic [MW-1:0]       ptop_q, ptop_d;
  logic [MW-1:0]       pbot_q, pbot_d;
  logic [BW-1:0]       base_q, base_d;
  logic [DW-1:0]       top_q, top_d;
  logic [DW-1:0]       bot_q, bot_d;
  logic                slot_free;
  logic                last;

  assign slot_free  = !outv_q || pop_i;
  assign last       = job_q.setup_error || ((k_q + 3'd1) == cfg_i.pixel_scale);
  assign empty_o    = !outv_q;
  assign out_item_o = out_q;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    out_d     = out_q;
    outv_d    = outv_q && !pop_i;
    k_d       = k_q;
    ptop_d    = ptop_q;
    pbot_d    = pbot_q;
    base_d    = base_q;
    top_d     = top_q;
    bot_d     = bot_q;
    job_pop_o = 1'b0;
    unique case (state_q)
      wmcd_pkg::BE_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          k_d       = '0;
          state_d   = job_i.setup_error ? wmcd_pkg::BE_EMIT : wmcd_pkg::BE_MULT;
        end
      end
      wmcd_pkg::BE_MULT: begin
        ptop_d  = MW'(p_q) * MW'(q_minus(job_q.col_max));
        pbot_d  = MW'(p_q) * MW'(q_minus(job_q.col_min));
        base_d  = BW'(job_q.column) * BW'(cfg_i.pixel_scale);
        state_d = wmcd_pkg::BE_ROW;
      end
      wmcd_pkg::BE_ROW: begin
        top_d   = row_of(ptop_q, p_q);
        bot_d   = row_of(pbot_q, p_q);
        state_d = wmcd_pkg::BE_EMIT;
      end
      wmcd_pkg::BE_EMIT: begin
        if (slot_free) begin
          outv_d = 1'b1;
          if (job_q.setup_error) begin
            out_d             = '0;
            out_d.setup_error = 1'b1;
          end else begin
            out_d.device_column = DW'(base_q + BW'(k_q));
            out_d.row_top       = top_q;
            out_d.row_bottom    = bot_q;
            out_d.setup_error   = 1'b0;
          end
          out_d.run_last = last;
          k_d            = k_q + 3'd1;
          if (last) begin
            state_d = wmcd_pkg::BE_IDLE;
          end
        end
      end
      default: begin
        state_d = wmcd_pkg::BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmcd_pkg::BE_IDLE;
      outv_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    out_q  <= out_d;
    p_q    <= PWD'(cfg_i.logical_height) * PWD'(cfg_i.pixel_scale);
    ptop_q <= ptop_d;
    pbot_q <= pbot_d;
    base_q <= base_d;
    top_q  <= top_d;
    bot_q  <= bot_d;
  end

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q && out_q.setup_error |-> out_q.run_last && (out_q.device_column == '0))
    else $error("A setup error item must stand alone.");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q && !out_q.setup_error && (p_q <= PWD'(16384)) |->
      out_q.row_top <= out_q.row_bottom)
    else $error("Span top row lies below its bottom row.");

  a_span_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wmcd_pkg::BE_EMIT && !job_q.setup_error |-> k_q < cfg_i.pixel_scale)
    else $error("More spans emitted than device columns per logical column.");

endmodule

/* sv/waveform_minmax_column_decimator.sv */
// Top level of the min/max waveform column decimator with its register file.
//
// An item inside the window passes through classification, a multiply, the column search,
// a second multiply, the update and, when it closes a column, a push into the queue before
// the next item is accepted; the search produces one quotient bit per cycle over CW bits,
// where CW is log2 of MAX_COLUMNS. Items before or past the window or after it is done only
// pass classification; under an invalid setup an error job is pushed as well. A closed
// column waits in a two-entry queue; the span generator takes it through a multiply and a
// row step and emits one span per device column; an output register holds each until popped.
// Registers are written through the configuration channel, which is always ready; any write
// to a listed register restarts the window. After reset the window starts at frame 0 and
// spans 4096 frames over 1024 columns of 256 rows at a pixel scale of one.
module waveform_minmax_column_decimator #(
  parameter int unsigned MAX_COLUMNS = wmcd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  wmcd_pkg::in_item_t                in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output wmcd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wmcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  wmcd_pkg::cfg_t cfg_q, cfg_d;
  logic           restart;
  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_empty;
  wmcd_pkg::job_t job_in;
  wmcd_pkg::job_t job_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (wmcd_pkg::cfg_reg_e'(cfg_index_i))
        wmcd_pkg::REG_WINDOW_OFFSET: begin
          cfg_d.window_offset = cfg_data_i;
          restart             = 1'b1;
        end
        wmcd_pkg::REG_WINDOW_FRAMES: begin
          cfg_d.window_frames = cfg_data_i;
          restart             = 1'b1;
        end
        wmcd_pkg::REG_LOGICAL_WIDTH: begin
          cfg_d.logical_width = cfg_data_i[12:0];
          restart             = 1'b1;
        end
        wmcd_pkg::REG_LOGICAL_HEIGHT: begin
          cfg_d.logical_height = cfg_data_i[12:0];
          restart              = 1'b1;
        end
        wmcd_pkg::REG_PIXEL_SCALE: begin
          cfg_d.pixel_scale = cfg_data_i[2:0];
          restart           = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wmcd_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wmcd_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .restart_i  (restart),
    .push_i     (push),
    .full_o     (full),
    .item_i     (in_item_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  wmcd_job_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (job_empty)
  );

  wmcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for the min/max waveform column decimator.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SB            = wmcd_pkg::SAMPLE_BITS;
  localparam int unsigned DW            = wmcd_pkg::DEV_W;
  localparam int unsigned IDX_W         = wmcd_pkg::CFG_IDX_W;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam longint     FULL_SCALE    = 64'sd32768;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_HALF,
    POP_SPARSE,
    POP_EVERY_FOURTH
  } pop_mode_e;

  // Tracks the window and the open column, and holds the spans still to come out.
  class span_tracker;
    wmcd_pkg::cfg_t                cfg;
    longint unsigned               cur_col;
    longint unsigned               col_end_frame;
    logic signed [SB-1:0]          run_min;
    logic signed [SB-1:0]          run_max;
    bit                            has_sample;
    bit                            done;
    wmcd_pkg::out_item_t           spans_due[$];
    int unsigned                   items_seen;
    int unsigned                   faults;

    function new();
      cfg = wmcd_pkg::CFG_RESET;
      items_seen = 0;
      faults = 0;
      restart();
    endfunction

    function longint unsigned boundary(longint unsigned col);
      if (cfg.logical_width == 0) return 0;
      return (longint'(cfg.window_frames) * (col + 1)) / cfg.logical_width;
    endfunction

    function void restart();
      cur_col = 0;
      col_end_frame = boundary(0);
      run_min = '0;
      run_max = '0;
      has_sample = 0;
      done = 0;
    endfunction

    function bit setup_invalid();
      return cfg.window_frames == 0 || cfg.logical_width == 0 ||
             cfg.logical_width > wmcd_pkg::MAX_COLUMNS_DEF || cfg.logical_height == 0 ||
             cfg.pixel_scale == 0 || cfg.pixel_scale > wmcd_pkg::MAX_SCALE ||
             cfg.window_frames < cfg.logical_width;
    endfunction

    function logic [DW-1:0] row_of(logic signed [SB-1:0] s, longint unsigned p);
      longint          d;
      longint unsigned row;
      d = FULL_SCALE - longint'(s);
      row = (p * longint'(d) + FULL_SCALE) / (2 * FULL_SCALE);
      if (row >= p) row = p - 1;
      return row[DW-1:0];
    endfunction

    function void apply_register(logic [IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        wmcd_pkg::REG_WINDOW_OFFSET:  cfg.window_offset = data;
        wmcd_pkg::REG_WINDOW_FRAMES:  cfg.window_frames = data;
        wmcd_pkg::REG_LOGICAL_WIDTH:  cfg.logical_width = data[12:0];
        wmcd_pkg::REG_LOGICAL_HEIGHT: cfg.logical_height = data[12:0];
        wmcd_pkg::REG_PIXEL_SCALE:    cfg.pixel_scale = data[2:0];
        default: return;
      endcase
      restart();
    endfunction

    function void note_frame(wmcd_pkg::in_item_t it);
      logic signed [SB-1:0]          s;
      longint unsigned               rel;
      longint unsigned               p;
      longint unsigned               col;
      logic [DW-1:0]                 top;
      logic [DW-1:0]                 bot;
      wmcd_pkg::out_item_t           sp;
      items_seen++;
      s = it.sample_value;
      sp = '0;
      if (setup_invalid()) begin
        sp.setup_error = 1'b1;
        sp.run_last = 1'b1;
        spans_due.push_back(sp);
        return;
      end
      if (done) return;
      if (it.frame_index < cfg.window_offset) begin
        has_sample = 0;
        if (it.end_of_clip) done = 1;
        return;
      end
      rel = longint'(it.frame_index) - longint'(cfg.window_offset);
      if (rel >= cfg.window_frames) begin
        has_sample = 0;
        done = 1;
        return;
      end
      col = ((rel + 1) * cfg.logical_width - 1) / cfg.window_frames;
      if (!has_sample || col != cur_col) begin
        cur_col = col;
        col_end_frame = boundary(col);
        run_min = s;
        run_max = s;
        has_sample = 1;
      end else begin
        if (s < run_min) run_min = s;
        if (s > run_max) run_max = s;
      end
      if (!it.end_of_clip && rel + 1 < col_end_frame) return;
      p = longint'(cfg.logical_height) * cfg.pixel_scale;
      top = row_of(run_max, p);
      bot = row_of(run_min, p);
      for (int unsigned k = 0; k < cfg.pixel_scale; k++) begin
        sp.device_column = DW'(cur_col * cfg.pixel_scale + k);
        sp.row_top = top;
        sp.row_bottom = bot;
        sp.setup_error = 1'b0;
        sp.run_last = (k + 1 == cfg.pixel_scale);
        spans_due.push_back(sp);
      end
      has_sample = 0;
      if (it.end_of_clip || cur_col + 1 >= cfg.logical_width) done = 1;
    endfunction

    function void check_span(wmcd_pkg::out_item_t got);
      wmcd_pkg::out_item_t want;
      if (spans_due.size() == 0) begin
        $error("span with nothing expected: column %0d", got.device_column);
        faults++;
        return;
      end
      want = spans_due.pop_front();
      if (got.device_column !== want.device_column) begin
        $error("device_column: expected %0d, got %0d", want.device_column, got.device_column);
        faults++;
      end
      if (got.row_top !== want.row_top) begin
        $error("row_top: expected %0d, got %0d", want.row_top, got.row_top);
        faults++;
      end
      if (got.row_bottom !== want.row_bottom) begin
        $error("row_bottom: expected %0d, got %0d", want.row_bottom, got.row_bottom);
        faults++;
      end
      if (got.setup_error !== want.setup_error) begin
        $error("setup_error: expected %0d, got %0d", want.setup_error, got.setup_error);
        faults++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
        faults++;
      end
    endfunction

    function int unsigned pending();
      return spans_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  wmcd_pkg::in_item_t   in_item;
  logic                 empty;
  logic                 pop;
  wmcd_pkg::out_item_t  out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [31:0]          cfg_data;

  span_tracker tracker = new();
  int unsigned burst_left;
  bit          hold_request;
  int unsigned cycle_count;

  waveform_minmax_column_decimator uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin : receiver
    pop_mode_e   mode;
    int unsigned mode_left;
    int unsigned hold_left;
    pop = 1'b0;
    mode = POP_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = pop_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        case (mode)
          POP_ALWAYS: pop = 1'b1;
          POP_HALF:   pop = 1'($urandom_range(0, 1));
          POP_SPARSE: pop = ($urandom_range(0, 5) == 0);
          default:    pop = (mode_left % 4 == 0);
        endcase
      end
      @(posedge clk);
      if (pop && !empty) tracker.check_span(out_item);
    end
  end

  task automatic send_frame(input logic [31:0] idx, input logic [SB-1:0] s,
                            input bit eoc);
    wmcd_pkg::in_item_t it;
    int unsigned        gap;
    it.frame_index = idx;
    it.sample_value = s;
    it.end_of_clip = eoc;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push = 1'b1;
    in_item = it;
    do @(posedge clk); while (full);
    tracker.note_frame(it);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [31:0] off, frames, width, height, scale);
    write_reg(wmcd_pkg::REG_WINDOW_OFFSET, off);
    write_reg(wmcd_pkg::REG_WINDOW_FRAMES, frames);
    write_reg(wmcd_pkg::REG_LOGICAL_WIDTH, width);
    write_reg(wmcd_pkg::REG_LOGICAL_HEIGHT, height);
    write_reg(wmcd_pkg::REG_PIXEL_SCALE, scale);
  endtask

  // Waits until every span has come out and any item still in flight has settled.
  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(input bit crowded);
    logic [31:0]                 off;
    logic [31:0]                 frames;
    logic [31:0]                 width;
    logic [31:0]                 height;
    logic [31:0]                 scale;
    logic [31:0]                 idx;
    logic [SB-1:0]               s;
    int unsigned                 n;
    int unsigned                 tail;
    int unsigned                 pick;
    case ($urandom_range(0, 7))
      0:       off = 32'd0;
      1:       off = 32'hFFFF_FFFF;
      2, 3:    off = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      default: off = $urandom_range(0, 3000);
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 2) width = 4096;
    else if (pick == 2) width = $urandom_range(0, 8191);
    else width = $urandom_range(1, 8);
    pick = $urandom_range(0, 19);
    if (pick < 2) frames = 32'hFFFF_FFFF;
    else if (pick == 2) frames = $urandom_range(0, width + 1);
    else if (width == 0) frames = $urandom_range(1, 8);
    else frames = width * $urandom_range(1, 5) + $urandom_range(0, width - 1);
    pick = $urandom_range(0, 19);
    if (pick < 2) height = 1;
    else if (pick < 4) height = 4096;
    else if (pick == 4) height = $urandom_range(0, 8191);
    else height = $urandom_range(1, 4096);
    scale = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    n = $urandom_range(8, 40);
    if (crowded) begin
      off = $urandom_range(0, 3000);
      frames = 16;
      width = 16;
      scale = 4;
      n = 24;
    end else if ($urandom_range(0, 3) == 0) begin
      width = width | ($urandom << 13);
      height = height | ($urandom << 13);
      scale = scale | ($urandom << 3);
    end

    drain();
    if ($urandom_range(0, 4) == 0)
      write_reg(IDX_W'(wmcd_pkg::REG_PIXEL_SCALE + $urandom_range(1, 3)), $urandom);
    set_geometry(off, frames, width, height, scale);

    if (crowded || frames == 0) begin
      idx = off;
    end else begin
      case ($urandom_range(0, 3))
        0:       idx = off - $urandom_range(1, 3);
        1:       idx = off + $urandom_range(frames - 1, 0);
        default: idx = off + ((frames > 40) ? frames - $urandom_range(1, 40) : 0);
      endcase
    end
    if (crowded) hold_request = 1;

    tail = 0;
    for (int unsigned k = 0; k < n && tail < 3; k++) begin
      case ($urandom_range(0, 9))
        0:       s = 16'h8000;
        1:       s = 16'h7FFF;
        default: s = SB'($urandom);
      endcase
      send_frame(idx, s, !crowded && $urandom_range(0, 39) == 0);
      if (tracker.done) tail++;
      pick = $urandom_range(0, 99);
      if (pick < 90) idx = idx + 1;
      else if (pick < 94) idx = idx + $urandom_range(2, 6);
      else if (pick >= 97) idx = idx - 1;
    end
  endtask

  initial begin
    int unsigned item_goal;
    int unsigned phase;
    rst_ni = 1'b0;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    hold_request = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    drain();

    // Reset geometry: four frames per column, a gap, then the clip ending inside a column.
    send_frame(32'd0, 16'h7FFF, 1'b0);
    send_frame(32'd1, 16'h8000, 1'b0);
    send_frame(32'd2, 16'h0000, 1'b0);
    send_frame(32'd3, 16'h0001, 1'b0);
    send_frame(32'd5, 16'hFFFF, 1'b0);
    send_frame(32'd9, 16'd100, 1'b0);
    send_frame(32'd10, -16'sd100, 1'b1);
    send_frame(32'd11, 16'd5, 1'b0);

    // Window at the top of the index range, one row, four device columns per column.
    drain();
    set_geometry(32'hFFFF_FFF0, 32'd8, 32'd2, 32'd1, 32'd4);
    send_frame(32'hFFFF_FFEF, 16'd7, 1'b0);
    send_frame(32'hFFFF_FFF0, 16'hFFFF, 1'b0);
    send_frame(32'hFFFF_FFF1, 16'h4000, 1'b0);
    send_frame(32'hFFFF_FFF2, 16'hC000, 1'b0);
    send_frame(32'hFFFF_FFF3, 16'h7FFF, 1'b0);
    send_frame(32'hFFFF_FFF4, 16'h0000, 1'b0);
    send_frame(32'hFFFF_FFF9, 16'h0000, 1'b0);

    // Invalid pixel scales.
    drain();
    write_reg(wmcd_pkg::REG_PIXEL_SCALE, 32'd0);
    send_frame(32'hFFFF_FFFF, 16'h8000, 1'b1);
    drain();
    write_reg(wmcd_pkg::REG_PIXEL_SCALE, 32'd7);
    send_frame(32'hFFFF_FFF5, 16'h1234, 1'b0);

    // The widest window in one column, closed by the end of the clip.
    drain();
    set_geometry(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd4096, 32'd4);
    send_frame(32'd7, 16'd123, 1'b0);
    send_frame(32'd8, -16'sd5, 1'b1);

    // Largest geometry: the last column lands on the last device columns.
    drain();
    set_geometry(32'd0, 32'd4096, 32'd4096, 32'd4096, 32'd4);
    send_frame(32'd4095, 16'h8000, 1'b0);

    // The clip ends before the window starts; an unmapped index leaves the state alone.
    drain();
    write_reg(wmcd_pkg::REG_WINDOW_OFFSET, 32'd10);
    write_reg(IDX_W'(wmcd_pkg::REG_PIXEL_SCALE + 1), 32'hFFFF_FFFF);
    send_frame(32'd3, 16'h0000, 1'b1);
    send_frame(32'd10, 16'h0000, 1'b0);

    item_goal = tracker.items_seen + RANDOM_ITEMS;
    phase = 0;
    while (tracker.items_seen < item_goal && phase < 400) begin
      random_phase(phase == 2);
      phase++;
    end

    drain();
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/wmcd_pkg.sv
sv/wmcd_front.sv
sv/wmcd_job_fifo.sv
sv/wmcd_back.sv
sv/waveform_minmax_column_decimator.sv
test/tb.sv
